### hw/rtl/d2q_pkg.sv
package d2q_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int HI_I      = (ONE_I < 32767) ? ONE_I : 32767;
  localparam int LO_I      = (ONE_I < 32768) ? -ONE_I : -32768;

  localparam int ELEM_W = 16;
  localparam int SUM_W  = ELEM_W + 1;                   // sum of two elements
  localparam int TR_W   = ELEM_W + 2;                   // sum of three elements
  localparam int RW     = ((FRAC_BITS + 2 > TR_W) ? FRAC_BITS + 2 : TR_W) + 1;
  localparam int VW     = RW - 1 + FRAC_BITS;           // radicand scaled by ONE
  localparam int ROOTW  = (VW + 1) / 2;                 // sqrt stages and root width
  localparam int SQW    = 2 * ROOTW;
  localparam int NW     = SUM_W + FRAC_BITS;            // dividend magnitude, div stages
  localparam int CW     = ((ROOTW > SUM_W) ? ROOTW : SUM_W) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // Numerators come in output order with the pivot component skipped.
  typedef struct packed {
    logic [1:0]              br;
    logic signed [RW-1:0]    rad;
    logic signed [SUM_W-1:0] n0;
    logic signed [SUM_W-1:0] n1;
    logic signed [SUM_W-1:0] n2;
  } d2q_job_t;

endpackage

### hw/rtl/d2q_front.sv
module d2q_front import d2q_pkg::*; (
  input  logic [9*ELEM_W-1:0] mat,
  output d2q_job_t            job
);

  logic signed [ELEM_W-1:0] m [9];
  logic signed [TR_W-1:0]   tr;
  logic signed [RW-1:0]     a00, a11, a22, one_r;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = mat[i*ELEM_W +: ELEM_W];
    end
  end

  assign tr    = TR_W'(m[0]) + TR_W'(m[4]) + TR_W'(m[8]);
  assign a00   = RW'(m[0]);
  assign a11   = RW'(m[4]);
  assign a22   = RW'(m[8]);
  assign one_r = RW'(ONE_I);

  always_comb begin
    if (tr > 0) begin
      job.br  = BR_TRACE;
      job.rad = one_r + RW'(tr);
      job.n0  = SUM_W'(m[7]) - SUM_W'(m[5]);
      job.n1  = SUM_W'(m[2]) - SUM_W'(m[6]);
      job.n2  = SUM_W'(m[3]) - SUM_W'(m[1]);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      job.br  = BR_X;
      job.rad = one_r + a00 - a11 - a22;
      job.n0  = SUM_W'(m[1]) + SUM_W'(m[3]);
      job.n1  = SUM_W'(m[2]) + SUM_W'(m[6]);
      job.n2  = SUM_W'(m[7]) - SUM_W'(m[5]);
    end else if (m[4] > m[8]) begin
      job.br  = BR_Y;
      job.rad = one_r + a11 - a00 - a22;
      job.n0  = SUM_W'(m[1]) + SUM_W'(m[3]);
      job.n1  = SUM_W'(m[5]) + SUM_W'(m[7]);
      job.n2  = SUM_W'(m[2]) - SUM_W'(m[6]);
    end else begin
      job.br  = BR_Z;
      job.rad = one_r + a22 - a00 - a11;
      job.n0  = SUM_W'(m[2]) + SUM_W'(m[6]);
      job.n1  = SUM_W'(m[5]) + SUM_W'(m[7]);
      job.n2  = SUM_W'(m[3]) - SUM_W'(m[1]);
    end
  end

endmodule

### hw/rtl/d2q_fifo.sv
module d2q_fifo import d2q_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  d2q_job_t din,
  output logic     full,
  input  logic     pop,
  output d2q_job_t dout,
  output logic     empty
);

  d2q_job_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

### hw/rtl/d2q_back.sv
module d2q_back import d2q_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  d2q_job_t    job,
  input  logic        job_valid,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser
);

  localparam logic signed [CW-1:0] HI_C = CW'(HI_I);
  localparam logic signed [CW-1:0] LO_C = CW'(LO_I);

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign pop = adv && job_valid;

  // square root, one result bit per stage
  logic                    sq_vld [ROOTW];
  logic [SQW-1:0]          sq_v   [ROOTW];
  logic [SQW-1:0]          sq_r   [ROOTW];
  logic [1:0]              sq_br  [ROOTW];
  logic                    sq_bad [ROOTW];
  logic signed [SUM_W-1:0] sq_n   [ROOTW][3];

  genvar k;
  generate
    for (k = 0; k < ROOTW; k++) begin : g_sq
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (ROOTW - 1 - k));
      logic                    i_vld, i_bad;
      logic [SQW-1:0]          i_v, i_r, trial;
      logic [1:0]              i_br;
      logic signed [SUM_W-1:0] i_n [3];

      if (k == 0) begin : g_in
        assign i_vld  = job_valid;
        assign i_bad  = (job.rad <= 0);
        assign i_v    = i_bad ? '0 : (SQW'(job.rad[RW-2:0]) << FRAC_BITS);
        assign i_r    = '0;
        assign i_br   = job.br;
        assign i_n[0] = job.n0;
        assign i_n[1] = job.n1;
        assign i_n[2] = job.n2;
      end else begin : g_in
        assign i_vld = sq_vld[k-1];
        assign i_bad = sq_bad[k-1];
        assign i_v   = sq_v[k-1];
        assign i_r   = sq_r[k-1];
        assign i_br  = sq_br[k-1];
        assign i_n   = sq_n[k-1];
      end

      assign trial = i_r + BIT;

      always_ff @(posedge clk) begin
        if (rst) begin
          sq_vld[k] <= 1'b0;
        end else if (adv) begin
          sq_vld[k] <= i_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          if (i_v >= trial) begin
            sq_v[k] <= i_v - trial;
            sq_r[k] <= (i_r >> 1) + BIT;
          end else begin
            sq_v[k] <= i_v;
            sq_r[k] <= i_r >> 1;
          end
          sq_br[k]  <= i_br;
          sq_bad[k] <= i_bad;
          sq_n[k]   <= i_n;
        end
      end
    end
  endgenerate

  // three restoring dividers side by side, one quotient bit per stage
  logic               dv_vld  [NW];
  logic [ROOTW:0]     dv_rem  [NW][3];
  logic [NW-1:0]      dv_dvd  [NW][3];
  logic [NW-1:0]      dv_q    [NW][3];
  logic               dv_neg  [NW][3];
  logic [ROOTW:0]     dv_s    [NW];
  logic [ROOTW-1:0]   dv_half [NW];
  logic [1:0]         dv_br   [NW];
  logic               dv_bad  [NW];

  genvar j;
  generate
    for (j = 0; j < NW; j++) begin : g_dv
      logic             i_vld, i_bad;
      logic [ROOTW:0]   i_s;
      logic [ROOTW-1:0] i_half;
      logic [1:0]       i_br;
      logic [ROOTW:0]   i_rem [3];
      logic [NW-1:0]    i_dvd [3];
      logic [NW-1:0]    i_q   [3];
      logic             i_neg [3];
      logic [ROOTW:0]   o_rem [3];
      logic             o_ge  [3];

      if (j == 0) begin : g_in
        logic [ROOTW-1:0] root;
        assign root   = sq_r[ROOTW-1][ROOTW-1:0];
        assign i_vld  = sq_vld[ROOTW-1];
        assign i_bad  = sq_bad[ROOTW-1];
        assign i_s    = {root, 1'b0};
        assign i_half = {1'b0, root[ROOTW-1:1]};
        assign i_br   = sq_br[ROOTW-1];
        always_comb begin
          for (int l = 0; l < 3; l++) begin
            logic [SUM_W-1:0] mag;
            i_neg[l] = sq_n[ROOTW-1][l] < 0;
            mag      = i_neg[l] ? SUM_W'(-sq_n[ROOTW-1][l]) : SUM_W'(sq_n[ROOTW-1][l]);
            i_dvd[l] = NW'(mag) << FRAC_BITS;
            i_rem[l] = '0;
            i_q[l]   = '0;
          end
        end
      end else begin : g_in
        assign i_vld  = dv_vld[j-1];
        assign i_bad  = dv_bad[j-1];
        assign i_s    = dv_s[j-1];
        assign i_half = dv_half[j-1];
        assign i_br   = dv_br[j-1];
        assign i_rem  = dv_rem[j-1];
        assign i_dvd  = dv_dvd[j-1];
        assign i_q    = dv_q[j-1];
        assign i_neg  = dv_neg[j-1];
      end

      always_comb begin
        for (int l = 0; l < 3; l++) begin
          logic [ROOTW+1:0] rsh;
          rsh     = {i_rem[l], i_dvd[l][NW-1]};
          o_ge[l] = rsh >= {1'b0, i_s};
          if (o_ge[l]) o_rem[l] = (ROOTW+1)'(rsh - {1'b0, i_s});
          else         o_rem[l] = rsh[ROOTW:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[j] <= 1'b0;
        end else if (adv) begin
          dv_vld[j] <= i_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          for (int l = 0; l < 3; l++) begin
            dv_rem[j][l] <= o_rem[l];
            dv_dvd[j][l] <= i_dvd[l] << 1;
            dv_q[j][l]   <= {i_q[l][NW-2:0], o_ge[l]};
            dv_neg[j][l] <= i_neg[l];
          end
          dv_s[j]    <= i_s;
          dv_half[j] <= i_half;
          dv_br[j]   <= i_br;
          dv_bad[j]  <= i_bad;
        end
      end
    end
  endgenerate

  // place pivot, clamp, output register
  logic signed [CW-1:0] qv [3];
  logic signed [CW-1:0] hv;
  logic signed [CW-1:0] comp [4];
  logic [15:0]          res [4];
  logic                 sat;

  assign hv = CW'(dv_half[NW-1]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_neg[NW-1][l]) qv[l] = -$signed(dv_q[NW-1][l][CW-1:0]);
      else                 qv[l] = $signed(dv_q[NW-1][l][CW-1:0]);
    end
    case (dv_br[NW-1])
      BR_TRACE: begin
        comp[0] = qv[0]; comp[1] = qv[1]; comp[2] = qv[2]; comp[3] = hv;
      end
      BR_X: begin
        comp[0] = hv;    comp[1] = qv[0]; comp[2] = qv[1]; comp[3] = qv[2];
      end
      BR_Y: begin
        comp[0] = qv[0]; comp[1] = hv;    comp[2] = qv[1]; comp[3] = qv[2];
      end
      default: begin
        comp[0] = qv[0]; comp[1] = qv[1]; comp[2] = hv;    comp[3] = qv[2];
      end
    endcase
    sat = dv_bad[NW-1];
    for (int c = 0; c < 4; c++) begin
      if (dv_bad[NW-1]) begin
        res[c] = '0;
      end else if (comp[c] > HI_C) begin
        res[c] = HI_C[15:0];
        sat    = 1'b1;
      end else if (comp[c] < LO_C) begin
        res[c] = LO_C[15:0];
        sat    = 1'b1;
      end else begin
        res[c] = comp[c][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dv_vld[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {res[3], res[2], res[1], res[0]};
      m_axis_tuser <= sat;
    end
  end

`ifndef ASSERT_OFF
  a_stage0_load: assert property (@(posedge clk) disable iff (rst)
    adv |=> sq_vld[0] == $past(job_valid))
    else $error("first stage valid does not follow the queue");

  a_bad_flags: assert property (@(posedge clk) disable iff (rst)
    (adv && dv_vld[NW-1] && dv_bad[NW-1]) |=> (m_axis_tuser[0] && m_axis_tdata == '0))
    else $error("bad radicand not flagged");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> (job_valid && adv))
    else $error("pop without job or while stalled");
`endif

endmodule

### hw/rtl/dcm_to_quaternion.sv
// Path from input accept to m_axis_tvalid at FRAC_BITS = 14: the queue,
//   ROOTW = 16 sqrt stages, NW = 31 divider stages and the output register.
// Throughput: one item per cycle while the output register is not held, set by the fully pipelined sqrt and dividers.
// The back end stalls as a whole only while its output register is held.
// Reset (rst, synchronous, active high) empties the queue and clears all valids.
module dcm_to_quaternion import d2q_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each, lowest first)
  output logic [63:0]   m_axis_tdata,
  // saturated
  output logic [0:0]    m_axis_tuser
);

  d2q_job_t front_job, queue_job;
  logic     q_full, q_empty, q_pop, q_push;

  // Front: trace test and pivot pick, purely combinational into the queue.
  d2q_front u_front (
    .mat (s_axis_tdata),
    .job (front_job)
  );

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  // Short queue lets intake keep going while the back end is held.
  d2q_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (queue_job),
    .empty (q_empty)
  );

  // Back: sqrt pipeline, three dividers, clamp and output register.
  d2q_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (queue_job),
    .job_valid     (!q_empty),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import d2q_pkg::*;

  typedef struct packed {
    logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } dcm_t;

  typedef struct packed {
    logic               sat;
    logic signed [15:0] w, z, y, x;
  } quat_t;

  localparam logic [1:0] PIV_TRACE = BR_TRACE;
  localparam logic [1:0] PIV_X     = BR_X;
  localparam logic [1:0] PIV_Y     = BR_Y;
  localparam logic [1:0] PIV_Z     = BR_Z;
  localparam longint     UNITY     = longint'(1) << FRAC_BITS;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;   // m00 .. m22, 16 bits each, lowest first
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // quat_x, quat_y, quat_z, quat_w, lowest first
  logic [0:0]   m_axis_tuser;   // saturated

  dcm_t   pending_mats[$];
  quat_t  expected_quats[$];
  int     err_cnt;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     hold_send;

  dcm_to_quaternion uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Integer square root, floor.
  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_q(longint v, inout logic sat);
    if (v > HI_I) begin
      sat = 1'b1;
      return 16'(HI_I);
    end
    if (v < LO_I) begin
      sat = 1'b1;
      return 16'(LO_I);
    end
    return 16'(v);
  endfunction

  // Division truncates toward zero, as SV longint division does.
  function automatic quat_t dcm_to_quat(dcm_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint tr, rad, root, s, half;
    longint qx, qy, qz, qw;
    logic [1:0] piv;
    logic sat;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    qx = 0; qy = 0; qz = 0; qw = 0;
    sat = 1'b0;
    if (tr > 0) begin
      piv = PIV_TRACE; rad = tr + UNITY;
    end else if (a00 > a11 && a00 > a22) begin
      piv = PIV_X; rad = UNITY + a00 - a11 - a22;
    end else if (a11 > a22) begin
      piv = PIV_Y; rad = UNITY + a11 - a00 - a22;
    end else begin
      piv = PIV_Z; rad = UNITY + a22 - a00 - a11;
    end
    if (rad <= 0) begin
      sat = 1'b1;
    end else begin
      root = floor_sqrt(rad * UNITY);
      s = 2 * root;
      half = root >> 1;
      if (s == 0) begin
        sat = 1'b1;
      end else begin
        case (piv)
          PIV_TRACE: begin
            qw = half;
            qx = ((a21 - a12) * UNITY) / s;
            qy = ((a02 - a20) * UNITY) / s;
            qz = ((a10 - a01) * UNITY) / s;
          end
          PIV_X: begin
            qw = ((a21 - a12) * UNITY) / s;
            qx = half;
            qy = ((a01 + a10) * UNITY) / s;
            qz = ((a02 + a20) * UNITY) / s;
          end
          PIV_Y: begin
            qw = ((a02 - a20) * UNITY) / s;
            qx = ((a01 + a10) * UNITY) / s;
            qy = half;
            qz = ((a12 + a21) * UNITY) / s;
          end
          default: begin
            qw = ((a10 - a01) * UNITY) / s;
            qx = ((a02 + a20) * UNITY) / s;
            qy = ((a12 + a21) * UNITY) / s;
            qz = half;
          end
        endcase
      end
    end
    q.x = clamp_q(qx, sat);
    q.y = clamp_q(qy, sat);
    q.z = clamp_q(qz, sat);
    q.w = clamp_q(qw, sat);
    q.sat = sat;
    return q;
  endfunction

  // Driver: advances only on acceptance, so tvalid never drops mid-handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_quats.push_back(dcm_to_quat(dcm_t'(s_axis_tdata)));
      end
      if (pending_mats.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_mats.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor plus random back-pressure on the result side.
  always @(posedge clk) begin
    quat_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_quats.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_quats.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.w !== want.w || got.sat !== want.sat) begin
            err_cnt++;
            $display("%0t: mismatch x/y/z/w/sat expected %0d %0d %0d %0d %b, actual %0d %0d %0d %0d %b",
                     $time, want.x, want.y, want.z, want.w, want.sat,
                     got.x, got.y, got.z, got.w, got.sat);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [15:0] rnd_elem();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);          // anything, incl. out of range
    if (k == 1) return 16'(16384);
    if (k == 2) return -16'sd16384;
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  // Random orthonormal-ish matrix: a rotation built from a random quaternion.
  function automatic dcm_t rnd_rotation();
    real a, b, c, d, n;
    dcm_t m;
    a = real'($urandom_range(2000)) - 1000.0;
    b = real'($urandom_range(2000)) - 1000.0;
    c = real'($urandom_range(2000)) - 1000.0;
    d = real'($urandom_range(2000)) - 1000.0;
    n = a*a + b*b + c*c + d*d;
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    n = 16384.0 / n;
    m.m00 = 16'($rtoi((a*a + b*b - c*c - d*d) * n));
    m.m01 = 16'($rtoi(2.0*(b*c - a*d) * n));
    m.m02 = 16'($rtoi(2.0*(b*d + a*c) * n));
    m.m10 = 16'($rtoi(2.0*(b*c + a*d) * n));
    m.m11 = 16'($rtoi((a*a - b*b + c*c - d*d) * n));
    m.m12 = 16'($rtoi(2.0*(c*d - a*b) * n));
    m.m20 = 16'($rtoi(2.0*(b*d - a*c) * n));
    m.m21 = 16'($rtoi(2.0*(c*d + a*b) * n));
    m.m22 = 16'($rtoi((a*a - b*b - c*c + d*d) * n));
    return m;
  endfunction

  task automatic drain_all();
    while (pending_mats.size() != 0 || s_axis_tvalid || expected_quats.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    dcm_t m;
    rst = 1'b1;
    err_cnt = 0;
    hold_send = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 56;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, each pivot branch, ties, extremes, zero, all-ones.
    m = '0; m.m00 = 16384; m.m11 = 16384; m.m22 = 16384; pending_mats.push_back(m);
    m = '0; m.m00 = 16384; m.m11 = -16384; m.m22 = -16384; pending_mats.push_back(m);
    m = '0; m.m00 = -16384; m.m11 = 16384; m.m22 = -16384; pending_mats.push_back(m);
    m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = 16384; pending_mats.push_back(m);
    m = '0; pending_mats.push_back(m);                          // trace zero, all tie
    m = '0; m.m00 = -100; m.m11 = -100; m.m22 = -300; pending_mats.push_back(m);
    m = '0; m.m00 = -300; m.m11 = -100; m.m22 = -100; pending_mats.push_back(m);
    m = {9{16'sd16384}}; pending_mats.push_back(m);
    m = {9{-16'sd16384}}; pending_mats.push_back(m);
    m = {9{16'h7fff}}; pending_mats.push_back(m);               // out of range
    m = {9{16'h8000}}; pending_mats.push_back(m);
    m = {9{16'hffff}}; pending_mats.push_back(m);
    m = {9{16'h5555}}; pending_mats.push_back(m);
    m = {9{16'haaaa}}; pending_mats.push_back(m);
    m = '0; m.m00 = 16'h8000; m.m01 = 16'h7fff; m.m10 = 16'h7fff;
    m.m02 = 16'h7fff; m.m20 = 16'h7fff; pending_mats.push_back(m); // big quotients
    m = '0; m.m11 = 16'h8000; m.m12 = 16'h7fff; m.m21 = 16'h8000; pending_mats.push_back(m);
    m = '0; m.m00 = 1; m.m21 = 16'h7fff; m.m12 = 16'h8000; pending_mats.push_back(m);
    drain_all();

    // Pressure: a batch of 20 random rotations queued in one go, then drained.
    hold_send = 1'b1;
    for (int i = 0; i < 20; i++) pending_mats.push_back(rnd_rotation());
    hold_send = 1'b0;
    drain_all();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 29 : 0;
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(3) != 0) begin
          pending_mats.push_back(rnd_rotation());
        end else begin
          for (int e = 0; e < 9; e++) m[e*16 +: 16] = rnd_elem();
          pending_mats.push_back(m);
        end
      end
      drain_all();
    end

    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/d2q_pkg.sv
hw/rtl/d2q_front.sv
hw/rtl/d2q_fifo.sv
hw/rtl/d2q_back.sv
hw/rtl/dcm_to_quaternion.sv
verif/tb_top.sv
